// ===== rtl/mpa_pkg.sv =====
// Shared constants, codes and types of the max pooling block.
`default_nettype none
package mpa_pkg;

   localparam int DEF_MAX_OUT_COLS = 64;
   localparam int DEF_MAX_WINDOW   = 8;
   localparam int DEF_SAMPLE_BITS  = 16;

   localparam int POS_BITS       = 9;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CFG_WIN_BITS   = 4;
   localparam int CFG_DIM_BITS   = 7;

   localparam logic [CFG_WIN_BITS-1:0] WINDOW_SIZE_RESET = 4'd2;
   localparam logic [CFG_DIM_BITS-1:0] OUT_ROWS_RESET    = 7'd14;
   localparam logic [CFG_DIM_BITS-1:0] OUT_COLS_RESET    = 7'd14;
   localparam int ROWS_MAX = 127;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE = 2'd0,
      CSR_OUT_ROWS    = 2'd1,
      CSR_OUT_COLS    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FE_SCALE,
      FE_ALIGN,
      FE_RUN
   } front_state_type;

   // per-sample control word from the front to the back
   typedef struct packed {
      logic                load;
      logic                emit;
      logic                last;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
   } mpa_tag_type;

   function automatic int idx_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/max_pool_with_argmax.sv =====
// Top level: streaming 2-D max pooling with argmax.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  sample
//   rsp      out        rsp_tvalid/rsp_tready  max_value, max_row, max_col; tlast plane_end
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One sample word per cycle sustained while req_tready is high; the window's last sample
// passes the queue, the store read stage and compare/update in the back end into the output register.
// After reset and after each csr write, req_tready is low while the front end
// rescales the plane size (FE_SCALE) and realigns its position counters (FE_ALIGN).
// A stalled result holds in the output register; the 4-word queue and the
// read stage keep accepting samples until they fill.
`default_nettype none
module max_pool_with_argmax #(
   parameter int MAX_OUT_COLS = mpa_pkg::DEF_MAX_OUT_COLS,
   parameter int MAX_WINDOW   = mpa_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS  = mpa_pkg::DEF_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,  // sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((SAMPLE_BITS+2*mpa_pkg::POS_BITS+7)/8)*8-1:0] rsp_tdata,
                                              // max_value, max_row, max_col
   output logic                               rsp_tlast,  // plane_end
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mpa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mpa_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import mpa_pkg::*;

   localparam int OC_BITS  = idx_bits(MAX_OUT_COLS);
   localparam int TAG_BITS = $bits(mpa_tag_type);
   localparam int Q_BITS   = SAMPLE_BITS + OC_BITS + TAG_BITS;
   localparam int RSP_BITS = ((SAMPLE_BITS + 2 * POS_BITS + 7) / 8) * 8;

   logic                   f_valid, f_ready;
   logic [SAMPLE_BITS-1:0] f_sample;
   logic [OC_BITS-1:0]     f_oc;
   mpa_tag_type            f_tag;

   logic                   b_valid, b_ready;
   logic [Q_BITS-1:0]      b_data;

   logic [SAMPLE_BITS-1:0] max_value;
   logic [POS_BITS-1:0]    max_row, max_col;

   assign csr_ready = 1'b1;

   mpa_front #(
      .MAX_OUT_COLS(MAX_OUT_COLS),
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_tvalid),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .req_ready  (req_tready),
      .push_ready (f_ready),
      .push_valid (f_valid),
      .push_sample(f_sample),
      .push_oc    (f_oc),
      .push_tag   (f_tag)
   );

   mpa_queue #(
      .DATA_BITS(Q_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_data ({f_sample, f_oc, f_tag}),
      .push_ready(f_ready),
      .pop_valid (b_valid),
      .pop_data  (b_data),
      .pop_ready (b_ready)
   );

   mpa_back #(
      .MAX_OUT_COLS(MAX_OUT_COLS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b_valid),
      .in_sample(b_data[Q_BITS-1 -: SAMPLE_BITS]),
      .in_oc    (b_data[TAG_BITS +: OC_BITS]),
      .in_tag   (b_data[TAG_BITS-1:0]),
      .in_ready (b_ready),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_value(max_value),
      .rsp_row  (max_row),
      .rsp_col  (max_col),
      .rsp_last (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({max_col, max_row, max_value});

endmodule
`default_nettype wire

// ===== rtl/mpa_front.sv =====
// Front end: config registers, plane position tracking and sample classification.
`default_nettype none
module mpa_front #(
   parameter int MAX_OUT_COLS = mpa_pkg::DEF_MAX_OUT_COLS,
   parameter int MAX_WINDOW   = mpa_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS  = mpa_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [mpa_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mpa_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  logic                                   req_valid,
   input  logic [SAMPLE_BITS-1:0]                 req_sample,
   output logic                                   req_ready,
   input  logic                                   push_ready,
   output logic                                   push_valid,
   output logic [SAMPLE_BITS-1:0]                 push_sample,
   output logic [mpa_pkg::idx_bits(MAX_OUT_COLS)-1:0] push_oc,
   output mpa_pkg::mpa_tag_type                   push_tag
);
   import mpa_pkg::*;

   localparam int OC_BITS    = idx_bits(MAX_OUT_COLS);
   localparam int WR_BITS    = idx_bits(MAX_WINDOW);
   localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int OCN_BITS   = $clog2(MAX_OUT_COLS + 1);
   localparam int ROW_BITS   = $clog2(ROWS_MAX * MAX_WINDOW + 1);
   localparam int COL_BITS   = $clog2(MAX_OUT_COLS * MAX_WINDOW + 1);
   localparam int DIV_BITS   = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
   localparam int RECIP_SH   = DIV_BITS + WIN_BITS;
   localparam int RECIP_BITS = RECIP_SH + 1;
   localparam int PROD_BITS  = DIV_BITS + RECIP_BITS;
   localparam int TAB_SIZE   = 2 ** WIN_BITS;

   front_state_type state_ff, state_in;

   logic [CFG_WIN_BITS-1:0] cfg_w_ff, cfg_w_in;
   logic [CFG_DIM_BITS-1:0] cfg_rows_ff, cfg_rows_in;
   logic [CFG_DIM_BITS-1:0] cfg_cols_ff, cfg_cols_in;

   logic [WIN_BITS-1:0] w_ff, w_in;
   logic [ROW_BITS-1:0] rows_ff, rows_in;
   logic [COL_BITS-1:0] cols_ff, cols_in;
   logic [DIV_BITS-1:0] q_r_ff, q_r_in;
   logic [DIV_BITS-1:0] q_c_ff, q_c_in;

   logic [ROW_BITS-1:0] r_ff, r_in;
   logic [COL_BITS-1:0] c_ff, c_in;
   logic [WR_BITS-1:0]  wr_ff, wr_in;
   logic [WR_BITS-1:0]  wc_ff, wc_in;
   logic [OC_BITS-1:0]  oc_ff, oc_in;
   // position lies outside the plane after a csr write; the next word restarts it
   logic                hold_ff, hold_in;

   logic [RECIP_BITS-1:0] recip_tab [TAB_SIZE];

   // ceil(2^RECIP_SH / w): exact quotient for every position value
   for (genvar g = 0; g < TAB_SIZE; g++) begin : g_recip
      localparam int RV = ((1 << RECIP_SH) + g - 1) / ((g == 0) ? 1 : g);
      assign recip_tab[g] = RECIP_BITS'(RV);
   end

   logic [WIN_BITS-1:0] w_new;
   logic [ROW_BITS-1:0] ro_new;
   logic [OCN_BITS-1:0] co_new;
   logic [PROD_BITS-1:0] prod_r, prod_c;
   logic [ROW_BITS-1:0] rem_r;
   logic [COL_BITS-1:0] rem_c;
   logic [ROW_BITS-1:0] r_cur;
   logic [COL_BITS-1:0] c_cur;
   logic win_col_end, win_row_end, row_end, col_end, accept;

   assign w_new  = (cfg_w_ff == '0) ? WIN_BITS'(1) :
                   (int'(cfg_w_ff) > MAX_WINDOW) ? WIN_BITS'(MAX_WINDOW) :
                   WIN_BITS'(cfg_w_ff);
   assign ro_new = (cfg_rows_ff == '0) ? ROW_BITS'(1) : ROW_BITS'(cfg_rows_ff);
   assign co_new = (cfg_cols_ff == '0) ? OCN_BITS'(1) :
                   (int'(cfg_cols_ff) > MAX_OUT_COLS) ? OCN_BITS'(MAX_OUT_COLS) :
                   OCN_BITS'(cfg_cols_ff);

   assign prod_r = PROD_BITS'(r_ff) * PROD_BITS'(recip_tab[w_new]);
   assign prod_c = PROD_BITS'(c_ff) * PROD_BITS'(recip_tab[w_new]);

   assign rem_r = r_ff - ROW_BITS'(q_r_ff[ROW_BITS-1:0]) * ROW_BITS'(w_ff);
   assign rem_c = c_ff - COL_BITS'(q_c_ff[COL_BITS-1:0]) * COL_BITS'(w_ff);

   assign r_cur = hold_ff ? '0 : r_ff;
   assign c_cur = hold_ff ? '0 : c_ff;

   assign win_col_end = (wc_ff == WR_BITS'(w_ff - 1'b1));
   assign win_row_end = (wr_ff == WR_BITS'(w_ff - 1'b1));
   assign row_end     = (r_cur == ROW_BITS'(rows_ff - 1'b1));
   assign col_end     = (c_cur == COL_BITS'(cols_ff - 1'b1));

   assign req_ready     = (state_ff == FE_RUN) && push_ready;
   assign accept        = req_valid && req_ready;
   assign push_valid    = accept;
   assign push_sample   = req_sample;
   assign push_oc       = oc_ff;
   assign push_tag.load = (wr_ff == '0) && (wc_ff == '0);
   assign push_tag.emit = win_row_end && win_col_end;
   assign push_tag.last = win_row_end && win_col_end && row_end && col_end;
   assign push_tag.row  = POS_BITS'(r_cur);
   assign push_tag.col  = POS_BITS'(c_cur);

   always_comb begin
      state_in    = state_ff;
      cfg_w_in    = cfg_w_ff;
      cfg_rows_in = cfg_rows_ff;
      cfg_cols_in = cfg_cols_ff;
      w_in        = w_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      q_r_in      = q_r_ff;
      q_c_in      = q_c_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      wr_in       = wr_ff;
      wc_in       = wc_ff;
      oc_in       = oc_ff;
      hold_in     = hold_ff;

      case (state_ff)
         FE_SCALE: begin
            w_in     = w_new;
            rows_in  = ROW_BITS'(ro_new * ROW_BITS'(w_new));
            cols_in  = COL_BITS'(COL_BITS'(co_new) * COL_BITS'(w_new));
            q_r_in   = prod_r[RECIP_SH +: DIV_BITS];
            q_c_in   = prod_c[RECIP_SH +: DIV_BITS];
            state_in = FE_ALIGN;
         end
         FE_ALIGN: begin
            if ((r_ff >= rows_ff) || (c_ff >= cols_ff)) begin
               wr_in   = '0;
               wc_in   = '0;
               oc_in   = '0;
               hold_in = 1'b1;
            end else begin
               wr_in   = rem_r[WR_BITS-1:0];
               wc_in   = rem_c[WR_BITS-1:0];
               oc_in   = q_c_ff[OC_BITS-1:0];
               hold_in = 1'b0;
            end
            state_in = FE_RUN;
         end
         FE_RUN: begin
            if (accept) begin
               hold_in = 1'b0;
               if (col_end) begin
                  c_in  = '0;
                  wc_in = '0;
                  oc_in = '0;
                  if (row_end) begin
                     r_in  = '0;
                     wr_in = '0;
                  end else begin
                     r_in  = ROW_BITS'(r_cur + 1'b1);
                     wr_in = win_row_end ? '0 : WR_BITS'(wr_ff + 1'b1);
                  end
               end else begin
                  r_in = r_cur;
                  c_in = COL_BITS'(c_cur + 1'b1);
                  if (win_col_end) begin
                     wc_in = '0;
                     oc_in = OC_BITS'(oc_ff + 1'b1);
                  end else begin
                     wc_in = WR_BITS'(wc_ff + 1'b1);
                  end
               end
            end
         end
         default: state_in = FE_SCALE;
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_SIZE: cfg_w_in    = csr_data[CFG_WIN_BITS-1:0];
            CSR_OUT_ROWS:    cfg_rows_in = csr_data[CFG_DIM_BITS-1:0];
            CSR_OUT_COLS:    cfg_cols_in = csr_data[CFG_DIM_BITS-1:0];
            default: ;
         endcase
         state_in = FE_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FE_SCALE;
         cfg_w_ff    <= WINDOW_SIZE_RESET;
         cfg_rows_ff <= OUT_ROWS_RESET;
         cfg_cols_ff <= OUT_COLS_RESET;
         r_ff        <= '0;
         c_ff        <= '0;
         wr_ff       <= '0;
         wc_ff       <= '0;
         oc_ff       <= '0;
         hold_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cfg_w_ff    <= cfg_w_in;
         cfg_rows_ff <= cfg_rows_in;
         cfg_cols_ff <= cfg_cols_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         wr_ff       <= wr_in;
         wc_ff       <= wc_in;
         oc_ff       <= oc_in;
         hold_ff     <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      rows_ff <= rows_in;
      cols_ff <= cols_in;
      q_r_ff  <= q_r_in;
      q_c_ff  <= q_c_in;
   end

endmodule
`default_nettype wire

// ===== rtl/mpa_queue.sv =====
// Short FIFO between the front end and the back end.
`default_nettype none
module mpa_queue #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 push_ready,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data,
   input  logic                 pop_ready
);
   import mpa_pkg::*;

   localparam int PTR_BITS = idx_bits(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     PTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     PTR_BITS'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_BITS'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mpa_back.sv =====
// Back end: per-column running maximum store, compare/update and result register.
`default_nettype none
module mpa_back #(
   parameter int MAX_OUT_COLS = mpa_pkg::DEF_MAX_OUT_COLS,
   parameter int SAMPLE_BITS  = mpa_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic [SAMPLE_BITS-1:0]                     in_sample,
   input  logic [mpa_pkg::idx_bits(MAX_OUT_COLS)-1:0] in_oc,
   input  mpa_pkg::mpa_tag_type                       in_tag,
   output logic                                       in_ready,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [SAMPLE_BITS-1:0]                     rsp_value,
   output logic [mpa_pkg::POS_BITS-1:0]               rsp_row,
   output logic [mpa_pkg::POS_BITS-1:0]               rsp_col,
   output logic                                       rsp_last
);
   import mpa_pkg::*;

   localparam int OC_BITS = idx_bits(MAX_OUT_COLS);

   logic [SAMPLE_BITS-1:0] best_value_mem [MAX_OUT_COLS];
   logic [POS_BITS-1:0]    best_row_mem   [MAX_OUT_COLS];
   logic [POS_BITS-1:0]    best_col_mem   [MAX_OUT_COLS];

   logic                   a_valid_ff;
   logic [SAMPLE_BITS-1:0] a_sample_ff;
   logic [OC_BITS-1:0]     a_oc_ff;
   mpa_tag_type            a_tag_ff;
   logic [SAMPLE_BITS-1:0] rd_value_ff;
   logic [POS_BITS-1:0]    rd_row_ff, rd_col_ff;

   // last store write, covers the read issued on the same edge
   logic                   fwd_valid_ff;
   logic [OC_BITS-1:0]     fwd_oc_ff;
   logic [SAMPLE_BITS-1:0] fwd_value_ff;
   logic [POS_BITS-1:0]    fwd_row_ff, fwd_col_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_value_ff;
   logic [POS_BITS-1:0]    rsp_row_ff, rsp_col_ff;
   logic                   rsp_last_ff;

   logic                   use_fwd, take, a_adv, pop;
   logic [SAMPLE_BITS-1:0] cur_value, new_value;
   logic [POS_BITS-1:0]    cur_row, cur_col, new_row, new_col;

   assign use_fwd   = fwd_valid_ff && (fwd_oc_ff == a_oc_ff);
   assign cur_value = use_fwd ? fwd_value_ff : rd_value_ff;
   assign cur_row   = use_fwd ? fwd_row_ff : rd_row_ff;
   assign cur_col   = use_fwd ? fwd_col_ff : rd_col_ff;
   assign take      = a_tag_ff.load || ($signed(a_sample_ff) >= $signed(cur_value));
   assign new_value = take ? a_sample_ff : cur_value;
   assign new_row   = take ? a_tag_ff.row : cur_row;
   assign new_col   = take ? a_tag_ff.col : cur_col;

   assign a_adv    = a_valid_ff && (!a_tag_ff.emit || !rsp_valid_ff || rsp_ready);
   assign in_ready = !a_valid_ff || a_adv;
   assign pop      = in_valid && in_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (a_adv && a_tag_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            a_valid_ff <= 1'b1;
         end else if (a_adv) begin
            a_valid_ff <= 1'b0;
         end
         if (a_adv) begin
            fwd_valid_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_sample_ff <= in_sample;
         a_oc_ff     <= in_oc;
         a_tag_ff    <= in_tag;
         rd_value_ff <= best_value_mem[in_oc];
         rd_row_ff   <= best_row_mem[in_oc];
         rd_col_ff   <= best_col_mem[in_oc];
      end
      if (a_adv) begin
         best_value_mem[a_oc_ff] <= new_value;
         best_row_mem[a_oc_ff]   <= new_row;
         best_col_mem[a_oc_ff]   <= new_col;
         fwd_oc_ff    <= a_oc_ff;
         fwd_value_ff <= new_value;
         fwd_row_ff   <= new_row;
         fwd_col_ff   <= new_col;
      end
      if (a_adv && a_tag_ff.emit) begin
         rsp_value_ff <= new_value;
         rsp_row_ff   <= new_row;
         rsp_col_ff   <= new_col;
         rsp_last_ff  <= a_tag_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
`default_nettype wire
